FILE: rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, command codes and the request and result beat types.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CAP_BITS   = 4;
  localparam int COUNT_BITS = 4;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_PROBE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                  command;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] put_value;
  } request_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    logic                  miss_error;
    logic [COUNT_BITS-1:0] entry_count;
  } result_t;

endpackage

FILE: rtl/lkvc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// An operation beat is taken on request at a clock edge where start is high
// and busy is low. Commands are put, get, probe and clear. Each operation
// gives one result beat on result, marked by done for a single cycle; the
// receiver cannot hold it off.
// The capacity register is written through cfg_data at an edge where
// cfg_valid and cfg_ready are both high; the user must write it only while no
// operation is in flight, as the block itself does not enforce this.
// The accepted beat is registered, then its result is registered and drives
// done. One operation is accepted every cycle while busy is low: the key
// compare over all slots, the recency update and the slot choice all fit in
// one register stage, and the value store has one write and one read port.
// Reset empties the store, sets capacity to eight and drops any operation in
// flight; busy is high while reset is asserted and for one cycle after.
// ----------------------------------------------------------------------------
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  request_t            request,
  output logic                done,
  output result_t             result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_BITS-1:0] cfg_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AGE_W = IDX_W;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > CAP_BITS) ? CNT_W : CAP_BITS) + 1;

  logic                busy_q;
  logic [CAP_BITS-1:0] capacity;
  logic                s1_valid;
  request_t            s1_req;

  logic [DEPTH-1:0]    valid;
  logic [DEPTH-1:0]    valid_next;
  logic [AGE_W-1:0]    age [DEPTH];
  logic [AGE_W-1:0]    age_next [DEPTH];
  logic [AGE_W-1:0]    touch_age [DEPTH];
  logic [KEY_BITS-1:0] slot_key [DEPTH];
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    count_m1;

  logic [DEPTH-1:0]    hit_vec;
  logic                hit_any;
  logic [IDX_W-1:0]    hit_idx;
  logic [AGE_W-1:0]    hit_age;
  logic [DEPTH-1:0]    evict_hit_vec;
  logic [DEPTH-1:0]    evict_miss_vec;
  logic [DEPTH-1:0]    valid_left;
  logic [IDX_W-1:0]    ins_idx;
  logic [CMP_W-1:0]    cap_eff;
  logic [CMP_W-1:0]    count_w;
  logic                over_hit;
  logic                over_miss;

  logic                key_we;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic                found_c;
  logic                miss_c;
  logic                get_hit_c;

  logic                r_valid;
  logic                r_found;
  logic                r_miss;
  logic                r_get_hit;
  logic [CNT_W-1:0]    r_count;

  assign busy      = busy_q || rst;
  assign cfg_ready = !busy;

  assign count_m1 = count - CNT_W'(1);
  assign count_w  = CMP_W'(count);

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
  end

  assign over_hit  = count_w > cap_eff;
  assign over_miss = (count_w + CMP_W'(1) > cap_eff) || (count_w >= CMP_W'(DEPTH));

  always_comb begin
    hit_idx = '0;
    hit_age = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_vec[i] = valid[i] && (slot_key[i] == s1_req.key);
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_age = hit_age | age[i];
      end
    end
    hit_any = |hit_vec;
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_vec[i]) begin
        touch_age[i] = '0;
      end else if (valid[i] && (age[i] < hit_age)) begin
        touch_age[i] = AGE_W'(age[i] + AGE_W'(1));
      end else begin
        touch_age[i] = age[i];
      end
      evict_hit_vec[i]  = valid[i] && (CNT_W'(touch_age[i]) == count_m1);
      evict_miss_vec[i] = valid[i] && (CNT_W'(age[i]) == count_m1);
    end
  end

  assign valid_left = over_miss ? (valid & ~evict_miss_vec) : valid;

  always_comb begin
    ins_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_left[i]) begin
        ins_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_next = valid;
    age_next   = age;
    count_next = count;
    key_we     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = hit_idx;
    found_c    = 1'b0;
    miss_c     = 1'b0;
    get_hit_c  = 1'b0;
    if (s1_valid) begin
      unique case (s1_req.command)
        CMD_CLEAR: begin
          valid_next = '0;
          count_next = '0;
          for (int i = 0; i < DEPTH; i++) begin
            age_next[i] = '0;
          end
        end
        CMD_PROBE: begin
          found_c = hit_any;
        end
        CMD_GET: begin
          found_c = hit_any;
          if (hit_any) begin
            get_hit_c = 1'b1;
            age_next  = touch_age;
          end else begin
            miss_c = 1'b1;
          end
        end
        CMD_PUT: begin
          found_c = hit_any;
          ram_we  = 1'b1;
          if (hit_any) begin
            age_next = touch_age;
            if (over_hit) begin
              for (int i = 0; i < DEPTH; i++) begin
                if (evict_hit_vec[i]) begin
                  valid_next[i] = 1'b0;
                  age_next[i]   = '0;
                end
              end
              count_next = count_m1;
            end
          end else begin
            ram_waddr = ins_idx;
            key_we    = 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              valid_next[i] = valid_left[i];
              age_next[i]   = valid_left[i] ? AGE_W'(age[i] + AGE_W'(1)) : '0;
            end
            valid_next[ins_idx] = 1'b1;
            age_next[ins_idx]   = '0;
            count_next = over_miss ? count : CNT_W'(count + CNT_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q   <= 1'b1;
      capacity <= CAP_RESET;
      s1_valid <= 1'b0;
      r_valid  <= 1'b0;
      valid    <= '0;
      count    <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        age[i] <= '0;
      end
    end else begin
      busy_q   <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      s1_valid <= start && !busy;
      r_valid  <= s1_valid;
      valid    <= valid_next;
      count    <= count_next;
      age      <= age_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_req <= request;
    end
    if (key_we) begin
      slot_key[ins_idx] <= s1_req.key;
    end
    r_found   <= found_c;
    r_miss    <= miss_c;
    r_get_hit <= get_hit_c;
    r_count   <= count_next;
  end

  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s1_req.put_value),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  assign done               = r_valid;
  assign result.found       = r_found;
  assign result.read_value  = r_get_hit ? ram_rdata : '0;
  assign result.miss_error  = r_miss;
  assign result.entry_count = COUNT_BITS'(r_count);

endmodule

FILE: rtl/lkvc_checker.sv
// ----------------------------------------------------------------------------
// LRU key-value cache checker
// Port-level properties of the cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker
  import lkvc_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input request_t            request,
  input logic                done,
  input result_t             result
);

  localparam int CNT_CHK_W = COUNT_BITS + 8;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 (done || $past(rst)))
    else $error("Accepted beat did not produce a result two cycles later.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (CNT_CHK_W'(result.entry_count) <= CNT_CHK_W'(DEPTH)))
    else $error("Entry count exceeds the number of slots.");

  a_miss_not_found: assert property (@(posedge clk) disable iff (rst)
    done && result.miss_error |-> !result.found && (result.read_value == '0))
    else $error("Miss reported together with a hit or a value.");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (rst)
    done && (result.read_value != '0) |-> result.found)
    else $error("Value returned without a hit.");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy && (request.command == CMD_CLEAR), 2) && done |->
      (result.entry_count == '0) && !result.found)
    else $error("Clear did not leave the store empty.");

endmodule

bind lru_key_value_cache lkvc_checker #(.DEPTH(DEPTH)) u_lkvc_checker (.*);
